>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the palette search checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define NPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define NPS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/nps_pkg.sv
// ---------------------------------------------------------------------------
// Nearest palette search package
// Shared types, codes, reset values and the default palette.
// ---------------------------------------------------------------------------
package nps_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned SIZE_W      = 7;
  localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;
  localparam int unsigned DIST_W      = 18;
  localparam logic [7:0] LEVEL_STEP   = 8'd63;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // default palette: four levels per channel, blue fastest, zero above 63
  function automatic rgb_t reset_entry(logic [8:0] idx);
    rgb_t c;
    c = '0;
    if (idx < 9'd64) begin
      c.red   = 8'(idx[5:4]) * LEVEL_STEP;
      c.green = 8'(idx[3:2]) * LEVEL_STEP;
      c.blue  = 8'(idx[1:0]) * LEVEL_STEP;
    end
    return c;
  endfunction

endpackage

>>> design/nps_if.sv
// ---------------------------------------------------------------------------
// Nearest palette search channels
// Request and response handshake interfaces.
// ---------------------------------------------------------------------------
interface nps_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [5:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, entry_index, red, green, blue, input ready);
  modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

interface nps_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  nearest_index;
  logic [17:0] nearest_distance_sq;

  modport source (output valid, found, nearest_index, nearest_distance_sq, input ready);
  modport sink   (input valid, found, nearest_index, nearest_distance_sq, output ready);
endinterface

>>> design/nps_palette_mem.sv
// ---------------------------------------------------------------------------
// Palette memory
// One write port, one registered read port; unwritten entries read as the
// default palette through per-entry valid bits.
// ---------------------------------------------------------------------------
module nps_palette_mem #(
  parameter int unsigned ENTRIES = nps_pkg::ENTRIES_DEF,
  localparam int unsigned IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  logic [IW-1:0]  waddr_i,
  input  nps_pkg::rgb_t  wdata_i,
  input  logic           re_i,
  input  logic [IW-1:0]  raddr_i,
  output logic           rvalid_o,
  output logic [IW-1:0]  rindex_o,
  output nps_pkg::rgb_t  rdata_o
);

  nps_pkg::rgb_t        mem_q [ENTRIES];
  logic [ENTRIES-1:0]   written_q;
  nps_pkg::rgb_t        rdata_q;
  logic                 rwritten_q;
  logic [IW-1:0]        raddr_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      rwritten_q <= written_q[raddr_i];
      raddr_q    <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= re_i;
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rvalid_o = rvalid_q;
  assign rindex_o = raddr_q;
  assign rdata_o  = rwritten_q ? rdata_q : nps_pkg::reset_entry(9'(raddr_q));

endmodule

>>> design/nps_dist_unit.sv
// ---------------------------------------------------------------------------
// Distance stage
// Squared RGB distance between a palette entry and the query color,
// registered with the entry index.
// ---------------------------------------------------------------------------
module nps_dist_unit #(
  parameter int unsigned ENTRIES = nps_pkg::ENTRIES_DEF,
  localparam int unsigned IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [IW-1:0]              index_i,
  input  nps_pkg::rgb_t              entry_i,
  input  nps_pkg::rgb_t              query_i,
  output logic                       valid_o,
  output logic [IW-1:0]              index_o,
  output logic [nps_pkg::DIST_W-1:0] dist_o
);

  logic [7:0]                 dr, dg, db;
  logic [nps_pkg::DIST_W-1:0] dist_d;
  logic [nps_pkg::DIST_W-1:0] dist_q;
  logic [IW-1:0]              index_q;
  logic                       valid_q;

  always_comb begin
    dr = (entry_i.red   > query_i.red)   ? entry_i.red   - query_i.red
                                         : query_i.red   - entry_i.red;
    dg = (entry_i.green > query_i.green) ? entry_i.green - query_i.green
                                         : query_i.green - entry_i.green;
    db = (entry_i.blue  > query_i.blue)  ? entry_i.blue  - query_i.blue
                                         : query_i.blue  - entry_i.blue;
    dist_d = nps_pkg::DIST_W'(16'(dr) * 16'(dr))
           + nps_pkg::DIST_W'(16'(dg) * 16'(dg))
           + nps_pkg::DIST_W'(16'(db) * 16'(db));
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dist_q  <= dist_d;
      index_q <= index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign index_o = index_q;
  assign dist_o  = dist_q;

endmodule

>>> design/nearest_palette_color_search.sv
// ---------------------------------------------------------------------------
// Nearest palette color search
// Palette table in memory; a query scans the first palette_size entries and
// returns the closest one by squared RGB distance, lowest index on ties.
//
//   channel  dir  word
//   req_i    in   func, entry_index, red, green, blue
//   rsp_o    out  found, nearest_index, nearest_distance_sq
//   cfg      in   palette_size (write enable + data)
//
// A write goes from accept through the finish state to the response register;
// a query reads n = min(palette_size, ENTRIES) entries, one memory read per
// cycle, through the read and distance registers, then takes the finish state.
// Reset clears the entry valid bits at once; no clearing pass.
// A response held by rsp_o stalls only the finish step; the next word is
// accepted while it waits.
// ---------------------------------------------------------------------------
module nearest_palette_color_search #(
  parameter int unsigned ENTRIES = nps_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  nps_req_if.sink                    req_i,
  nps_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [nps_pkg::SIZE_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned NW  = (CW > nps_pkg::SIZE_W) ? CW : nps_pkg::SIZE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e                       state_q;
  logic [nps_pkg::SIZE_W-1:0]   size_q;
  logic [NW-1:0]                cnt_q;
  logic [NW-1:0]                n_q;
  logic [NW-1:0]                n_d;
  nps_pkg::rgb_t                query_q;
  logic                         have_q;
  logic [IW-1:0]                best_i_q;
  logic [nps_pkg::DIST_W-1:0]   best_d_q;
  logic                         out_vld_q;
  logic                         out_found_q;
  logic [5:0]                   out_index_q;
  logic [nps_pkg::DIST_W-1:0]   out_dist_q;

  logic                         accept;
  logic                         wr_in_range;
  logic                         mem_we;
  logic                         mem_re;
  logic                         mem_rvalid;
  logic [IW-1:0]                mem_rindex;
  nps_pkg::rgb_t                mem_rdata;
  nps_pkg::rgb_t                in_rgb;
  logic                         dist_vld;
  logic [IW-1:0]                dist_idx;
  logic [nps_pkg::DIST_W-1:0]   dist_val;
  logic                         slot_free;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign in_rgb      = '{red: req_i.red, green: req_i.green, blue: req_i.blue};
  assign wr_in_range = (32'(req_i.entry_index) < 32'(ENTRIES));
  assign mem_we      = accept && (req_i.func == nps_pkg::FUNC_WRITE) && wr_in_range;
  assign mem_re      = (state_q == ST_SCAN) && (cnt_q < n_q);
  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign n_d         = (NW'(size_q) > NW'(ENTRIES)) ? NW'(ENTRIES) : NW'(size_q);

  nps_palette_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (mem_we),
    .waddr_i  (IW'(req_i.entry_index)),
    .wdata_i  (in_rgb),
    .re_i     (mem_re),
    .raddr_i  (IW'(cnt_q)),
    .rvalid_o (mem_rvalid),
    .rindex_o (mem_rindex),
    .rdata_o  (mem_rdata)
  );

  nps_dist_unit #(.ENTRIES(ENTRIES)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mem_rvalid),
    .index_i (mem_rindex),
    .entry_i (mem_rdata),
    .query_i (query_q),
    .valid_o (dist_vld),
    .index_o (dist_idx),
    .dist_o  (dist_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= nps_pkg::SIZE_RST;
      cnt_q       <= '0;
      n_q         <= '0;
      query_q     <= '0;
      have_q      <= 1'b0;
      best_i_q    <= '0;
      best_d_q    <= '0;
      out_vld_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_index_q <= '0;
      out_dist_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if ((state_q == ST_FIN) && slot_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            have_q   <= 1'b0;
            best_i_q <= '0;
            best_d_q <= '0;
            cnt_q    <= '0;
            n_q      <= n_d;
            query_q  <= in_rgb;
            state_q  <= (req_i.func == nps_pkg::FUNC_QUERY) ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          if (mem_re) begin
            cnt_q <= cnt_q + NW'(1);
          end
          if (dist_vld && (!have_q || (dist_val < best_d_q))) begin
            have_q   <= 1'b1;
            best_i_q <= dist_idx;
            best_d_q <= dist_val;
          end
          if (!mem_re && !mem_rvalid && !dist_vld) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_found_q <= have_q;
            out_index_q <= 6'(best_i_q);
            out_dist_q  <= best_d_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid               = out_vld_q;
  assign rsp_o.found               = out_found_q;
  assign rsp_o.nearest_index       = out_index_q;
  assign rsp_o.nearest_distance_sq = out_dist_q;

endmodule

>>> design/nps_checker.sv
// ---------------------------------------------------------------------------
// Nearest palette search checker
// Port-level checks on response words, busy behavior and palette size.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nps_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  logic                       rsp_found_i,
  input  logic [5:0]                 rsp_index_i,
  input  logic [17:0]                rsp_dist_i,
  input  logic                       cfg_we_i,
  input  logic [nps_pkg::SIZE_W-1:0] cfg_wdata_i
);

  logic [nps_pkg::SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= nps_pkg::SIZE_RST;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  `NPS_ASSERT_NR(a_rsp_idle_in_reset, clk_i, !rst_ni |-> !rsp_valid_i, "response valid during reset")
  `NPS_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_index_i) && $stable(rsp_dist_i), "stalled response changed")
  `NPS_ASSERT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while busy")
  `NPS_ASSERT(a_not_found_zero, clk_i, rst_ni, rsp_valid_i && !rsp_found_i |-> rsp_index_i == 6'd0 && rsp_dist_i == 18'd0, "empty response not zero")
  `NPS_ASSERT(a_found_in_size, clk_i, rst_ni, rsp_valid_i && rsp_found_i |-> {1'b0, rsp_index_i} < size_q, "winner outside searched range")

endmodule

bind nearest_palette_color_search nps_checker u_nps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_found_i (rsp_o.found),
  .rsp_index_i (rsp_o.nearest_index),
  .rsp_dist_i  (rsp_o.nearest_distance_sq),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);

>>> tb/sv/nps_search_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Palette search result checker
// Watches the request, response and size register traffic of the nearest
// palette color search, keeps its own copy of the palette and search size,
// works out the response for every accepted request word and compares each
// response word field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module nps_search_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  nps_req_if                         req_mon,
  nps_rsp_if                         rsp_mon,
  input  logic                       cfg_we_i,
  input  logic [nps_pkg::SIZE_W-1:0] cfg_wdata_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                pending_o
);
  import nps_pkg::*;

  localparam int unsigned NUM_ENTRIES = ENTRIES_DEF;

  typedef struct packed {
    logic              found;
    logic [5:0]        index;
    logic [DIST_W-1:0] distance;
  } match_t;

  rgb_t              palette_q [NUM_ENTRIES];
  logic [SIZE_W-1:0] search_size_q;
  match_t            expected_matches [$];

  function automatic rgb_t default_color(int unsigned i);
    rgb_t c;
    c.red   = 8'((i >> 4) & 3) * 8'd63;
    c.green = 8'((i >> 2) & 3) * 8'd63;
    c.blue  = 8'(i & 3) * 8'd63;
    return c;
  endfunction

  function automatic logic [DIST_W-1:0] chan_dist_sq(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return DIST_W'(d) * DIST_W'(d);
  endfunction

  function automatic match_t nearest_match(rgb_t color);
    match_t            m;
    int unsigned       span;
    logic [DIST_W-1:0] d;
    m = '0;
    span = (search_size_q > NUM_ENTRIES) ? NUM_ENTRIES : search_size_q;
    for (int unsigned i = 0; i < span; i++) begin
      d = chan_dist_sq(palette_q[i].red, color.red)
        + chan_dist_sq(palette_q[i].green, color.green)
        + chan_dist_sq(palette_q[i].blue, color.blue);
      if (!m.found || d < m.distance) begin
        m.found    = 1'b1;
        m.index    = 6'(i);
        m.distance = d;
      end
    end
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_t exp_m;
    rgb_t   color;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_ENTRIES; i++) palette_q[i] = default_color(i);
      search_size_q = SIZE_RST;
      expected_matches.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: response word with nothing outstanding: found=%0b index=%0d dist=%0d",
                   $time, rsp_mon.found, rsp_mon.nearest_index, rsp_mon.nearest_distance_sq);
          mismatch_count_o++;
        end else begin
          exp_m = expected_matches.pop_front();
          if (rsp_mon.found !== exp_m.found || rsp_mon.nearest_index !== exp_m.index ||
              rsp_mon.nearest_distance_sq !== exp_m.distance) begin
            if (rsp_mon.found !== exp_m.found)
              $display("%0t: found expected %0b actual %0b",
                       $time, exp_m.found, rsp_mon.found);
            if (rsp_mon.nearest_index !== exp_m.index)
              $display("%0t: nearest_index expected %0d actual %0d",
                       $time, exp_m.index, rsp_mon.nearest_index);
            if (rsp_mon.nearest_distance_sq !== exp_m.distance)
              $display("%0t: nearest_distance_sq expected %0d actual %0d",
                       $time, exp_m.distance, rsp_mon.nearest_distance_sq);
            mismatch_count_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        color.red   = req_mon.red;
        color.green = req_mon.green;
        color.blue  = req_mon.blue;
        if (req_mon.func == FUNC_QUERY) begin
          expected_matches.push_back(nearest_match(color));
        end else begin
          if (req_mon.entry_index < NUM_ENTRIES) palette_q[req_mon.entry_index] = color;
          expected_matches.push_back('0);
        end
      end
      if (cfg_we_i) search_size_q = cfg_wdata_i;
      pending_o = expected_matches.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Nearest palette color search testbench
// Drives palette writes and color queries under several search sizes, with
// random idle cycles on both channels and one long response hold-off, and
// reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_top;
  import nps_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 165;
  localparam int unsigned PHASE_COUNT  = 10;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int unsigned       mismatch_count;
  int unsigned       pending;
  int unsigned       quiet_cycles = 0;
  bit                idle_en = 1'b1;
  bit                hold_req = 1'b0;
  rgb_t              color_pool [8];

  nps_req_if req_ch ();
  nps_rsp_if rsp_ch ();

  nearest_palette_color_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  nps_search_checker nearest_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_ch),
    .rsp_mon          (rsp_ch),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // response side: random idling, long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      rsp_ch.ready <= !(idle_en && $urandom_range(99) < 33);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic rgb_t mk_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  function automatic rgb_t pick_color();
    rgb_t        c;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) begin
      c = color_pool[$urandom_range(7)];
    end else if (sel < 40) begin
      c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      c.green = $urandom_range(1) ? 8'hFF : 8'h00;
      c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end else begin
      c = 24'($urandom);
    end
    return c;
  endfunction

  task automatic send_word(logic func, logic [5:0] idx, rgb_t c);
    while (idle_en && $urandom_range(99) < 33) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= func;
    req_ch.entry_index <= idx;
    req_ch.red         <= c.red;
    req_ch.green       <= c.green;
    req_ch.blue        <= c.blue;
    forever begin
      @(posedge clk_i);
      if (req_ch.ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] s);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_word();
    if ($urandom_range(99) < 30) begin
      send_word(FUNC_WRITE, 6'($urandom), pick_color());
    end else begin
      send_word(FUNC_QUERY, 6'($urandom), pick_color());
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_size;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_WRITE;
    req_ch.entry_index = '0;
    req_ch.red         = '0;
    req_ch.green       = '0;
    req_ch.blue        = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default palette: exact hits, far corner, ties after duplicate writes
    send_word(FUNC_QUERY, 6'd0,  mk_rgb(8'd0, 8'd0, 8'd0));
    send_word(FUNC_QUERY, 6'd63, mk_rgb(8'd255, 8'd255, 8'd255));
    send_word(FUNC_QUERY, 6'd21, mk_rgb(8'd189, 8'd0, 8'd63));
    send_word(FUNC_QUERY, 6'd42, mk_rgb(8'd31, 8'd32, 8'd94));
    send_word(FUNC_WRITE, 6'd0,  mk_rgb(8'd255, 8'd255, 8'd255));
    send_word(FUNC_WRITE, 6'd63, mk_rgb(8'd0, 8'd0, 8'd0));
    send_word(FUNC_QUERY, 6'd0,  mk_rgb(8'd0, 8'd0, 8'd0));
    send_word(FUNC_QUERY, 6'd0,  mk_rgb(8'd255, 8'd255, 8'd255));
    send_word(FUNC_WRITE, 6'd10, mk_rgb(8'd126, 8'd126, 8'd126));
    send_word(FUNC_QUERY, 6'd63, mk_rgb(8'd126, 8'd126, 8'd126));
    send_word(FUNC_QUERY, 6'd5,  mk_rgb(8'd120, 8'd130, 8'd126));
    send_word(FUNC_WRITE, 6'd33, mk_rgb(8'hAA, 8'h55, 8'hF0));
    send_word(FUNC_QUERY, 6'd33, mk_rgb(8'hAA, 8'h55, 8'hF0));

    // empty palette
    set_size(7'd0);
    send_word(FUNC_QUERY, 6'd0,  mk_rgb(8'd255, 8'd0, 8'd255));
    send_word(FUNC_WRITE, 6'd5,  mk_rgb(8'd1, 8'd2, 8'd3));
    send_word(FUNC_QUERY, 6'd63, mk_rgb(8'd0, 8'd0, 8'd0));

    // single entry, largest distance
    set_size(7'd1);
    send_word(FUNC_WRITE, 6'd0,  mk_rgb(8'd0, 8'd0, 8'd0));
    send_word(FUNC_QUERY, 6'd0,  mk_rgb(8'd255, 8'd255, 8'd255));

    // oversized search size saturates at the table depth
    set_size(7'd127);
    send_word(FUNC_QUERY, 6'd17, mk_rgb(8'd200, 8'd100, 8'd50));
    send_word(FUNC_QUERY, 6'd0,  mk_rgb(8'd0, 8'd0, 8'd0));

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: phase_size = 7'd64;
        1: phase_size = 7'd127;
        2: phase_size = 7'd1;
        3: phase_size = 7'd2;
        4: phase_size = 7'd0;
        5: phase_size = 7'd33;
        6: phase_size = 7'd65;
        7: phase_size = 7'd8;
        default: phase_size = 7'($urandom_range(127));
      endcase
      set_size(phase_size);
      foreach (color_pool[i]) color_pool[i] = 24'($urandom);
      idle_en = (phase != 3);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 20) hold_req = 1'b1;
        random_word();
      end
    end
    idle_en = 1'b1;

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
